/* rtl/pdwt_pkg.sv */
`timescale 1ns / 1ps

package pdwt_pkg;

    // default geometry
    localparam int TAP_COUNT_DEF   = 6;
    localparam int SAMPLE_BITS_DEF = 16;

    // fixed field widths
    localparam int COEF_BITS     = 16;
    localparam int TAPS_PER_REG  = 3;
    localparam int TAP_REG_BITS  = COEF_BITS * TAPS_PER_REG;
    localparam int ACC_BITS      = 40;
    localparam int PAIR_BITS     = 15;
    localparam int LEN_BITS      = 16;
    localparam int HEAD_MAX      = 4;
    localparam int HEAD_IDX_BITS = $clog2(HEAD_MAX);

    localparam int JOB_QUEUE_DEPTH = 4;

    localparam logic [LEN_BITS-1:0] MIN_LEN         = LEN_BITS'(6);
    localparam logic [LEN_BITS-1:0] BLOCK_LEN_RESET = LEN_BITS'(64);

    // what the front tells the back about one accepted sample
    typedef struct packed {
        logic                 has_reg;
        logic                 reg_end;
        logic [PAIR_BITS-1:0] reg_pair;
        logic                 has_wrap;
        logic [PAIR_BITS-1:0] half;
    } pdwt_job_ctrl_t;

    // pair tag that rides along the back pipeline
    typedef struct packed {
        logic [PAIR_BITS-1:0] pair;
        logic                 block_end;
    } pdwt_tag_t;

endpackage

/* rtl/pdwt_job_fifo.sv */
`timescale 1ns / 1ps

module pdwt_job_fifo import pdwt_pkg::*; #(
    parameter int WIDTH = 8,
    parameter int DEPTH = JOB_QUEUE_DEPTH
) (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             push,
    output logic             push_ready,
    input  logic [WIDTH-1:0] push_data,
    output logic             pop_valid,
    input  logic             pop,
    output logic [WIDTH-1:0] pop_data
);

    localparam int PTR_BITS = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_BITS = $clog2(DEPTH + 1);
    localparam logic [PTR_BITS-1:0] PTR_LAST = PTR_BITS'(DEPTH - 1);

    logic [WIDTH-1:0]    mem_reg [DEPTH];
    logic [PTR_BITS-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PTR_BITS-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CNT_BITS-1:0] count_reg, count_next;

    assign push_ready = (count_reg != CNT_BITS'(DEPTH));
    assign pop_valid  = (count_reg != '0);
    assign pop_data   = mem_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push)
        begin
            wr_ptr_next = (wr_ptr_reg == PTR_LAST) ? '0 : wr_ptr_reg + PTR_BITS'(1);
        end
        if (pop)
        begin
            rd_ptr_next = (rd_ptr_reg == PTR_LAST) ? '0 : rd_ptr_reg + PTR_BITS'(1);
        end
        if (push && !pop)
        begin
            count_next = count_reg + CNT_BITS'(1);
        end
        else if (pop && !push)
        begin
            count_next = count_reg - CNT_BITS'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            mem_reg[wr_ptr_reg] <= push_data;
        end
    end

endmodule

/* rtl/pdwt_front.sv */
`timescale 1ns / 1ps

module pdwt_front import pdwt_pkg::*; #(
    parameter int TAP_COUNT   = TAP_COUNT_DEF,
    parameter int SAMPLE_BITS = SAMPLE_BITS_DEF
) (
    input  logic                                  clk,
    input  logic                                  rst_n,
    input  logic                                  sample_valid,
    output logic                                  sample_ready,
    input  logic signed [SAMPLE_BITS-1:0]         sample,
    input  logic [LEN_BITS-1:0]                   n_eff,
    input  logic                                  restart,
    output logic                                  job_push,
    input  logic                                  job_ready,
    output pdwt_job_ctrl_t                        job_ctrl,
    output logic [TAP_COUNT-1:0][SAMPLE_BITS-1:0] job_window,
    output logic [HEAD_MAX-1:0][SAMPLE_BITS-1:0]  job_head
);

    localparam int WRAP_PAIRS = (TAP_COUNT - 1) / 2;

    logic [LEN_BITS-1:0]                   count_reg, count_next;
    logic [LEN_BITS-1:0]                   k;
    logic                                  blk_last;
    logic [LEN_BITS:0]                     span;
    logic [LEN_BITS:0]                     rel;
    logic [TAP_COUNT-1:0][SAMPLE_BITS-1:0] window_reg, window_next;
    logic [HEAD_MAX-1:0][SAMPLE_BITS-1:0]  head_reg;
    logic                                  accept;

    assign sample_ready = job_ready;
    assign accept       = sample_valid && sample_ready;

    always_comb
    begin
        k        = (count_reg < n_eff) ? count_reg : '0;
        blk_last = (k == n_eff - LEN_BITS'(1));

        // newest sample at position 0
        window_next = window_reg;
        for (int d = TAP_COUNT - 1; d > 0; d--)
        begin
            window_next[d] = window_reg[d-1];
        end
        window_next[0] = sample;

        // pair (k+1-T)/2 completes when that offset is even
        span = {1'b0, k} + (LEN_BITS+1)'(1);
        rel  = span - (LEN_BITS+1)'(TAP_COUNT);

        job_ctrl.has_reg  = (span >= (LEN_BITS+1)'(TAP_COUNT)) && !rel[0];
        job_ctrl.reg_pair = rel[PAIR_BITS:1];
        job_ctrl.half     = n_eff[LEN_BITS-1:1];
        job_ctrl.reg_end  = (rel[PAIR_BITS:1] == n_eff[LEN_BITS-1:1] - PAIR_BITS'(1));
        job_ctrl.has_wrap = blk_last && (WRAP_PAIRS != 0);

        count_next = blk_last ? '0 : k + LEN_BITS'(1);
    end

    assign job_push   = accept && (job_ctrl.has_reg || job_ctrl.has_wrap);
    assign job_window = window_next;
    assign job_head   = head_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg  <= '0;
            window_reg <= '0;
        end
        else if (restart)
        begin
            count_reg <= '0;
        end
        else if (accept)
        begin
            count_reg  <= count_next;
            window_reg <= window_next;
        end
    end

    // first samples of the block, kept for the wrap-around pairs
    always_ff @(posedge clk)
    begin
        if (accept && (k < LEN_BITS'(TAP_COUNT - 2)))
        begin
            head_reg[k[HEAD_IDX_BITS-1:0]] <= sample;
        end
    end

endmodule

/* rtl/pdwt_back.sv */
`timescale 1ns / 1ps

module pdwt_back import pdwt_pkg::*; #(
    parameter int TAP_COUNT   = TAP_COUNT_DEF,
    parameter int SAMPLE_BITS = SAMPLE_BITS_DEF
) (
    input  logic                                  clk,
    input  logic                                  rst_n,
    input  logic                                  job_valid,
    output logic                                  job_pop,
    input  pdwt_job_ctrl_t                        job_ctrl,
    input  logic [TAP_COUNT-1:0][SAMPLE_BITS-1:0] job_window,
    input  logic [HEAD_MAX-1:0][SAMPLE_BITS-1:0]  job_head,
    input  logic [TAP_REG_BITS-1:0]               low_first,
    input  logic [TAP_REG_BITS-1:0]               low_second,
    input  logic [TAP_REG_BITS-1:0]               high_first,
    input  logic [TAP_REG_BITS-1:0]               high_second,
    output logic                                  result_valid,
    input  logic                                  result_ready,
    output logic signed [ACC_BITS-1:0]            approx_value,
    output logic signed [ACC_BITS-1:0]            detail_value,
    output logic [PAIR_BITS-1:0]                  pair_index,
    output logic                                  block_end
);

    localparam int WRAP_PAIRS    = (TAP_COUNT - 1) / 2;
    localparam int STEP_BITS     = (WRAP_PAIRS > 0) ? $clog2(WRAP_PAIRS + 1) : 1;
    localparam int PROD_BITS     = SAMPLE_BITS + COEF_BITS;
    localparam int WIN_IDX_BITS  = (TAP_COUNT > 1) ? $clog2(TAP_COUNT) : 1;
    localparam logic [STEP_BITS-1:0] LAST_WITH_REG  = STEP_BITS'(WRAP_PAIRS);
    localparam logic [STEP_BITS-1:0] LAST_WRAP_ONLY = STEP_BITS'(WRAP_PAIRS - 1);

    logic signed [COEF_BITS-1:0]   coef_lo [TAP_COUNT];
    logic signed [COEF_BITS-1:0]   coef_hi [TAP_COUNT];
    logic signed [SAMPLE_BITS-1:0] opnd    [TAP_COUNT];

    logic [STEP_BITS-1:0] step_reg, step_next;
    logic [STEP_BITS-1:0] wrap_q;
    logic                 is_reg;
    logic                 last_step;
    logic                 issue;
    logic                 o_adv;
    logic                 p_adv;
    pdwt_tag_t            issue_tag;
    int                   off;

    logic                        p_valid_reg;
    logic signed [PROD_BITS-1:0] prod_lo_reg [TAP_COUNT];
    logic signed [PROD_BITS-1:0] prod_hi_reg [TAP_COUNT];
    pdwt_tag_t                   p_tag_reg;

    logic signed [ACC_BITS-1:0] sum_lo;
    logic signed [ACC_BITS-1:0] sum_hi;

    logic                       out_valid_reg;
    logic signed [ACC_BITS-1:0] approx_reg;
    logic signed [ACC_BITS-1:0] detail_reg;
    pdwt_tag_t                  out_tag_reg;

    // taps 0..2 in the first word, 3..5 in the second
    always_comb
    begin
        for (int j = 0; j < TAP_COUNT; j++)
        begin
            if (j < TAPS_PER_REG)
            begin
                coef_lo[j] = low_first[COEF_BITS*j +: COEF_BITS];
                coef_hi[j] = high_first[COEF_BITS*j +: COEF_BITS];
            end
            else
            begin
                coef_lo[j] = low_second[COEF_BITS*(j-TAPS_PER_REG) +: COEF_BITS];
                coef_hi[j] = high_second[COEF_BITS*(j-TAPS_PER_REG) +: COEF_BITS];
            end
        end
    end

    assign o_adv = !out_valid_reg || result_ready;
    assign p_adv = !p_valid_reg || o_adv;
    assign issue = job_valid && p_adv;

    // one result per cycle while the pipeline can advance: the regular pair first, then the wrap pairs
    always_comb
    begin
        is_reg    = job_ctrl.has_reg && (step_reg == '0);
        wrap_q    = job_ctrl.has_reg ? step_reg - STEP_BITS'(1) : step_reg;
        last_step = !job_ctrl.has_wrap
                    || (step_reg == (job_ctrl.has_reg ? LAST_WITH_REG : LAST_WRAP_ONLY));
        step_next = step_reg;
        if (issue)
        begin
            step_next = last_step ? '0 : step_reg + STEP_BITS'(1);
        end

        off = 0;
        for (int j = 0; j < TAP_COUNT; j++)
        begin
            opnd[j] = job_window[TAP_COUNT-1-j];
            if (!is_reg)
            begin
                for (int qq = 0; qq < WRAP_PAIRS; qq++)
                begin
                    if (wrap_q == STEP_BITS'(qq))
                    begin
                        // offset past the block end; negative means still in the window
                        off = 2 * (qq - WRAP_PAIRS) + j;
                        if (off >= 0)
                        begin
                            opnd[j] = job_head[HEAD_IDX_BITS'(off)];
                        end
                        else
                        begin
                            opnd[j] = job_window[WIN_IDX_BITS'(-off - 1)];
                        end
                    end
                end
            end
        end

        if (is_reg)
        begin
            issue_tag.pair      = job_ctrl.reg_pair;
            issue_tag.block_end = job_ctrl.reg_end;
        end
        else
        begin
            issue_tag.pair      = job_ctrl.half - PAIR_BITS'(WRAP_PAIRS)
                                  + PAIR_BITS'(wrap_q);
            issue_tag.block_end = (wrap_q == LAST_WRAP_ONLY);
        end
    end

    assign job_pop = issue && last_step;

    always_comb
    begin
        sum_lo = '0;
        sum_hi = '0;
        for (int j = 0; j < TAP_COUNT; j++)
        begin
            sum_lo = sum_lo + ACC_BITS'(prod_lo_reg[j]);
            sum_hi = sum_hi + ACC_BITS'(prod_hi_reg[j]);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            step_reg      <= '0;
            p_valid_reg   <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            step_reg <= step_next;
            if (p_adv)
            begin
                p_valid_reg <= issue;
            end
            if (o_adv)
            begin
                out_valid_reg <= p_valid_reg;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (issue)
        begin
            for (int j = 0; j < TAP_COUNT; j++)
            begin
                prod_lo_reg[j] <= opnd[j] * coef_lo[j];
                prod_hi_reg[j] <= opnd[j] * coef_hi[j];
            end
            p_tag_reg <= issue_tag;
        end
        if (p_valid_reg && o_adv)
        begin
            approx_reg  <= sum_lo;
            detail_reg  <= sum_hi;
            out_tag_reg <= p_tag_reg;
        end
    end

    assign result_valid = out_valid_reg;
    assign approx_value = approx_reg;
    assign detail_value = detail_reg;
    assign pair_index   = out_tag_reg.pair;
    assign block_end    = out_tag_reg.block_end;

endmodule

/* rtl/periodic_dwt_analysis_stage.sv */
`timescale 1ns / 1ps

// One level of periodic wavelet analysis with 6-tap low-pass and high-pass filters.
// Samples enter on sample/sample_valid/sample_ready, one beat per sample, one per
// cycle at full rate. Each result beat on result_valid/result_ready carries the
// approximation and detail sums of one pair, its pair_index, and block_end on the
// last pair of the block.
// Pair i leaves after the beat of sample 2i+5; its result passes the job queue and
// the back end. The last sample of a block also yields the two wrap-around pairs,
// built from the held first four samples, so that beat makes three results. The
// back end makes one result per cycle when not stalled, through a multiply stage
// and a sum stage; a four-entry job queue between front and back absorbs the burst
// at the end of a block and any stall on the result side. When the queue is full
// the sample side stops taking beats; a stalled result holds its beat.
// Reset clears the sample counter, the window and all pipeline valids; the taps
// reset to zero and block_len to 64. Writing block_len starts a new block.
// Registers sit at byte address 8*i (64-bit data): low taps 0..2, low taps 3..5,
// high taps 0..2, high taps 3..5, block_len.

module periodic_dwt_analysis_stage import pdwt_pkg::*; #(
    parameter int TAP_COUNT   = TAP_COUNT_DEF,
    parameter int SAMPLE_BITS = SAMPLE_BITS_DEF
) (
    input  logic                          clk,
    input  logic                          rst_n,
    // configuration port
    input  logic                          psel,
    input  logic                          penable,
    input  logic                          pwrite,
    input  logic [5:0]                    paddr,
    input  logic [63:0]                   pwdata,
    output logic [63:0]                   prdata,
    output logic                          pready,
    // sample channel
    input  logic                          sample_valid,
    output logic                          sample_ready,
    input  logic signed [SAMPLE_BITS-1:0] sample,
    // result channel
    output logic                          result_valid,
    input  logic                          result_ready,
    output logic signed [ACC_BITS-1:0]    approx_value,
    output logic signed [ACC_BITS-1:0]    detail_value,
    output logic [PAIR_BITS-1:0]          pair_index,
    output logic                          block_end
);

    // register map, index = paddr[5:3]
    localparam logic [2:0] REG_LOW_FIRST   = 3'd0;
    localparam logic [2:0] REG_LOW_SECOND  = 3'd1;
    localparam logic [2:0] REG_HIGH_FIRST  = 3'd2;
    localparam logic [2:0] REG_HIGH_SECOND = 3'd3;
    localparam logic [2:0] REG_BLOCK_LEN   = 3'd4;

    localparam int JOB_BITS = $bits(pdwt_job_ctrl_t) + TAP_COUNT * SAMPLE_BITS
                              + HEAD_MAX * SAMPLE_BITS;

    logic [TAP_REG_BITS-1:0] low_first_reg;
    logic [TAP_REG_BITS-1:0] low_second_reg;
    logic [TAP_REG_BITS-1:0] high_first_reg;
    logic [TAP_REG_BITS-1:0] high_second_reg;
    logic [LEN_BITS-1:0]     block_len_reg;

    logic                    cfg_write;
    logic [2:0]              reg_idx;
    logic                    restart;
    logic [LEN_BITS-1:0]     len_even;
    logic [LEN_BITS-1:0]     n_eff;

    // front to queue
    logic                                  job_push;
    logic                                  job_ready;
    pdwt_job_ctrl_t                        push_ctrl;
    logic [TAP_COUNT-1:0][SAMPLE_BITS-1:0] push_window;
    logic [HEAD_MAX-1:0][SAMPLE_BITS-1:0]  push_head;

    // queue to back
    logic                                  job_valid;
    logic                                  job_pop;
    logic [JOB_BITS-1:0]                   pop_data;
    pdwt_job_ctrl_t                        pop_ctrl;
    logic [TAP_COUNT-1:0][SAMPLE_BITS-1:0] pop_window;
    logic [HEAD_MAX-1:0][SAMPLE_BITS-1:0]  pop_head;

    // ------------------------------------------------------------------
    // configuration registers, written in the access phase
    // ------------------------------------------------------------------
    assign pready    = 1'b1;
    assign cfg_write = psel && penable && pwrite && pready;
    assign reg_idx   = paddr[5:3];
    assign restart   = cfg_write && (reg_idx == REG_BLOCK_LEN);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            low_first_reg   <= '0;
            low_second_reg  <= '0;
            high_first_reg  <= '0;
            high_second_reg <= '0;
            block_len_reg   <= BLOCK_LEN_RESET;
        end
        else if (cfg_write)
        begin
            unique case (reg_idx)
                REG_LOW_FIRST:   low_first_reg   <= pwdata[TAP_REG_BITS-1:0];
                REG_LOW_SECOND:  low_second_reg  <= pwdata[TAP_REG_BITS-1:0];
                REG_HIGH_FIRST:  high_first_reg  <= pwdata[TAP_REG_BITS-1:0];
                REG_HIGH_SECOND: high_second_reg <= pwdata[TAP_REG_BITS-1:0];
                REG_BLOCK_LEN:   block_len_reg   <= pwdata[LEN_BITS-1:0];
                default:         ;  // unmapped addresses are ignored
            endcase
        end
    end

    always_comb
    begin
        unique case (reg_idx)
            REG_LOW_FIRST:   prdata = 64'(low_first_reg);
            REG_LOW_SECOND:  prdata = 64'(low_second_reg);
            REG_HIGH_FIRST:  prdata = 64'(high_first_reg);
            REG_HIGH_SECOND: prdata = 64'(high_second_reg);
            REG_BLOCK_LEN:   prdata = 64'(block_len_reg);
            default:         prdata = '0;
        endcase
    end

    // working length: low bit dropped, raised to the minimum of six
    assign len_even = {block_len_reg[LEN_BITS-1:1], 1'b0};
    assign n_eff    = (len_even < MIN_LEN) ? MIN_LEN : len_even;

    // ------------------------------------------------------------------
    // front: counts the block position, keeps the window and head samples
    // ------------------------------------------------------------------
    pdwt_front #(
        .TAP_COUNT   (TAP_COUNT),
        .SAMPLE_BITS (SAMPLE_BITS)
    ) u_front (
        .clk          (clk),
        .rst_n        (rst_n),
        .sample_valid (sample_valid),
        .sample_ready (sample_ready),
        .sample       (sample),
        .n_eff        (n_eff),
        .restart      (restart),
        .job_push     (job_push),
        .job_ready    (job_ready),
        .job_ctrl     (push_ctrl),
        .job_window   (push_window),
        .job_head     (push_head)
    );

    // ------------------------------------------------------------------
    // job queue, one entry per sample that yields results
    // ------------------------------------------------------------------
    pdwt_job_fifo #(
        .WIDTH (JOB_BITS),
        .DEPTH (JOB_QUEUE_DEPTH)
    ) u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (job_push),
        .push_ready (job_ready),
        .push_data  ({push_ctrl, push_window, push_head}),
        .pop_valid  (job_valid),
        .pop        (job_pop),
        .pop_data   (pop_data)
    );

    assign {pop_ctrl, pop_window, pop_head} = pop_data;

    // ------------------------------------------------------------------
    // back: operand select, twelve multiplies, sums, output register
    // ------------------------------------------------------------------
    pdwt_back #(
        .TAP_COUNT   (TAP_COUNT),
        .SAMPLE_BITS (SAMPLE_BITS)
    ) u_back (
        .clk          (clk),
        .rst_n        (rst_n),
        .job_valid    (job_valid),
        .job_pop      (job_pop),
        .job_ctrl     (pop_ctrl),
        .job_window   (pop_window),
        .job_head     (pop_head),
        .low_first    (low_first_reg),
        .low_second   (low_second_reg),
        .high_first   (high_first_reg),
        .high_second  (high_second_reg),
        .result_valid (result_valid),
        .result_ready (result_ready),
        .approx_value (approx_value),
        .detail_value (detail_value),
        .pair_index   (pair_index),
        .block_end    (block_end)
    );

    // ------------------------------------------------------------------
    // checks
    // ------------------------------------------------------------------
    // a cycle spent in reset leaves no result beat on offer
    assert property (@(posedge clk) !rst_n |=> !result_valid)
        else $error("result offered after reset");

    // the front only hands over a job when the queue has room
    assert property (@(posedge clk) disable iff (!rst_n) job_push |-> job_ready)
        else $error("job pushed into a full queue");

    // the back only retires a job that is really there
    assert property (@(posedge clk) disable iff (!rst_n) job_pop |-> job_valid)
        else $error("job popped from an empty queue");

endmodule
